// ===== src/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and constants of the three-class call queue
// Codes, widths, record layouts and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  // Queue geometry
  localparam int CLASS_DEPTH = 16;
  localparam int NUM_CLASSES = 3;
  localparam int NUM_ENTRIES = NUM_CLASSES * CLASS_DEPTH;
  localparam int PTR_W       = $clog2(CLASS_DEPTH);
  localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);

  // Field widths
  localparam int OP_W     = 2;
  localparam int CLS_W    = 2;
  localparam int ID_W     = 32;
  localparam int PKT_W    = 16;
  localparam int STATUS_W = 3;
  localparam int DCNT_W   = 5;

  // Request codes
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_SERVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_DISMISS = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  // Class codes, lowest priority first
  localparam logic [CLS_W-1:0] CLS_DATA  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_VOICE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_EMERG = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DISMISSED = 3'd4;

  // Class-specific attributes of a stored call
  typedef struct packed {
    logic             roaming;
    logic             hidden;
    logic [PKT_W-1:0] packets;
  } extra_t;

  // One stored call record
  typedef struct packed {
    logic [ID_W-1:0] caller;
    logic [ID_W-1:0] receiver;
    extra_t          extra;
  } entry_t;

  // Request payload
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CLS_W-1:0] call_class;
    logic [ID_W-1:0]  caller_id;
    logic [ID_W-1:0]  receiver_id;
    logic [PKT_W-1:0] packet_count;
    logic             hidden_flag;
    logic             roaming_flag;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CLS_W-1:0]    served_class;
    logic [ID_W-1:0]     served_caller;
    logic [ID_W-1:0]     served_receiver;
    logic [PKT_W-1:0]    served_packets;
    logic                served_hidden;
    logic                served_roaming;
    logic [DCNT_W-1:0]   dismissed_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic req_load;  // capture the accepted request
    logic rd_en;     // read the head entry of the serve class
    logic commit;    // update queue state and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } sts_t;

endpackage

// ===== src/tcpq_if.sv =====
// ----------------------------------------------------------------------------
// tcpq_if: valid/ready channels of the call queue
// Request channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface tcpq_in_if import tcpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [CLS_W-1:0] call_class;
  logic [ID_W-1:0]  caller_id;
  logic [ID_W-1:0]  receiver_id;
  logic [PKT_W-1:0] packet_count;
  logic             hidden_flag;
  logic             roaming_flag;

  modport source (output valid, op, call_class, caller_id, receiver_id, packet_count,
                  hidden_flag, roaming_flag, input ready);
  modport sink (input valid, op, call_class, caller_id, receiver_id, packet_count,
                hidden_flag, roaming_flag, output ready);
endinterface

interface tcpq_out_if import tcpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CLS_W-1:0]    served_class;
  logic [ID_W-1:0]     served_caller;
  logic [ID_W-1:0]     served_receiver;
  logic [PKT_W-1:0]    served_packets;
  logic                served_hidden;
  logic                served_roaming;
  logic [DCNT_W-1:0]   dismissed_count;

  modport source (output valid, status, served_class, served_caller, served_receiver,
                  served_packets, served_hidden, served_roaming, dismissed_count,
                  input ready);
  modport sink (input valid, status, served_class, served_caller, served_receiver,
                served_packets, served_hidden, served_roaming, dismissed_count,
                output ready);
endinterface

// ===== src/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpq_ctrl: request sequencer
// Accepts one request, steps it through read and commit, then frees the input.
// ----------------------------------------------------------------------------
module tcpq_ctrl import tcpq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;  // head read in flight
  localparam logic [1:0] S_LOAD = 2'd2;  // wait for result register, then commit

  logic [1:0] state_r, state_nxt;
  logic       xfer;

  assign in_ready = (state_r == S_IDLE);
  assign xfer     = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.req_load = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      S_IDLE: begin
        // Unused op code is swallowed without a result
        if (xfer && in_op != OP_NONE) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tcpq_dp.sv =====
// ----------------------------------------------------------------------------
// tcpq_dp: queue datapath
// Per-class head/tail/count, shared record memory and the result register.
// ----------------------------------------------------------------------------
module tcpq_dp import tcpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_item_t  in_item,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  // Request latch
  in_item_t req_r;

  // Class pointers and fill counts
  logic [PTR_W-1:0] head_r  [NUM_CLASSES];
  logic [PTR_W-1:0] tail_r  [NUM_CLASSES];
  logic [CNT_W-1:0] count_r [NUM_CLASSES];

  // Record memory and registered read data
  entry_t mem_r [NUM_ENTRIES];
  entry_t rd_data_r;

  // Result register
  out_item_t out_r, out_nxt;
  logic      out_valid_r;

  logic [CLS_W-1:0]  ins_cls, srv_cls;
  logic              ins_full, srv_empty;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_entry;
  logic              wr_en;
  logic [31:0]       data_cnt_ext;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] c,
                                                  input logic [PTR_W-1:0] p);
    slot_addr = ADDR_W'(c) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(p);
  endfunction

  // Insert target: code three falls back to data
  assign ins_cls  = (req_r.call_class == CLS_VOICE || req_r.call_class == CLS_EMERG) ?
                    req_r.call_class : CLS_DATA;
  assign ins_full = (count_r[ins_cls] == CNT_W'(CLASS_DEPTH));
  assign wr_addr  = slot_addr(ins_cls, tail_r[ins_cls]);

  // Serve target: highest non-empty class
  always_comb begin
    srv_empty = 1'b0;
    if (count_r[CLS_EMERG] != '0) begin
      srv_cls = CLS_EMERG;
    end else if (count_r[CLS_VOICE] != '0) begin
      srv_cls = CLS_VOICE;
    end else begin
      srv_cls   = CLS_DATA;
      srv_empty = (count_r[CLS_DATA] == '0);
    end
  end
  assign rd_addr = slot_addr(srv_cls, head_r[srv_cls]);

  // Stored record keeps only the attributes of its class
  always_comb begin
    wr_entry.caller   = req_r.caller_id;
    wr_entry.receiver = req_r.receiver_id;
    wr_entry.extra    = '0;
    if (ins_cls == CLS_DATA) begin
      wr_entry.extra.packets = req_r.packet_count;
    end else if (ins_cls == CLS_VOICE) begin
      wr_entry.extra.hidden  = req_r.hidden_flag;
      wr_entry.extra.roaming = req_r.roaming_flag;
    end
  end

  assign wr_en        = cmd.commit && (req_r.op == OP_INSERT) && !ins_full;
  assign data_cnt_ext = 32'(count_r[CLS_DATA]);

  // Result value; unrelated fields stay zero
  always_comb begin
    out_nxt = '0;
    case (req_r.op)
      OP_INSERT: out_nxt.status = ins_full ? ST_FULL : ST_INSERTED;
      OP_SERVE: begin
        if (srv_empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.status          = ST_SERVED;
          out_nxt.served_class    = srv_cls;
          out_nxt.served_caller   = rd_data_r.caller;
          out_nxt.served_receiver = rd_data_r.receiver;
          out_nxt.served_packets  = rd_data_r.extra.packets;
          out_nxt.served_hidden   = rd_data_r.extra.hidden;
          out_nxt.served_roaming  = rd_data_r.extra.roaming;
        end
      end
      OP_DISMISS: begin
        out_nxt.status          = ST_DISMISSED;
        out_nxt.dismissed_count = data_cnt_ext[DCNT_W-1:0];
      end
      default: out_nxt = '0;
    endcase
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_item     = out_r;
  assign out_valid    = out_valid_r;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_item;
    end
  end

  // Record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Pointer and count update at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      case (req_r.op)
        OP_INSERT: begin
          if (!ins_full) begin
            tail_r[ins_cls]  <= next_ptr(tail_r[ins_cls]);
            count_r[ins_cls] <= count_r[ins_cls] + 1'b1;
          end
        end
        OP_SERVE: begin
          if (!srv_empty) begin
            head_r[srv_cls]  <= next_ptr(head_r[srv_cls]);
            count_r[srv_cls] <= count_r[srv_cls] - 1'b1;
          end
        end
        OP_DISMISS: begin
          head_r[CLS_DATA]  <= '0;
          tail_r[CLS_DATA]  <= '0;
          count_r[CLS_DATA] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== src/three_class_priority_call_queue.sv =====
// ----------------------------------------------------------------------------
// three_class_priority_call_queue: strict priority call queue, three classes
// Emergency over voice over data, FIFO order within each class.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request channel (valid/ready). op selects insert, serve or
//            dismiss-all-data; op code three is taken and dropped silently.
//   out_ch : one result per insert, serve or dismiss request (valid/ready),
//            held in an output register.
// Sequence: an accepted request passes the head read (S_EXEC), then waits in
//   S_LOAD for a free output register and commits; the result is registered
//   at commit, after the registered head read of the record memory.
// in_ch.ready is high only while no request is in flight. A new request may be
//   taken while the previous result still waits in the output register; if
//   the receiver stalls, the next request holds before commit and the input
//   stays closed until the register drains.
// Reset (synchronous, rst_n low): all classes empty, no result pending. The
//   record memory is not cleared; only written entries ever reach a result.
// ----------------------------------------------------------------------------
module three_class_priority_call_queue import tcpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tcpq_in_if.sink   in_ch,
  tcpq_out_if.source out_ch
);

  cmd_t      cmd;
  sts_t      sts;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  // Pack request payload
  assign in_item.op           = in_ch.op;
  assign in_item.call_class   = in_ch.call_class;
  assign in_item.caller_id    = in_ch.caller_id;
  assign in_item.receiver_id  = in_ch.receiver_id;
  assign in_item.packet_count = in_ch.packet_count;
  assign in_item.hidden_flag  = in_ch.hidden_flag;
  assign in_item.roaming_flag = in_ch.roaming_flag;

  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcpq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

  // Unpack result payload
  assign out_ch.valid           = out_valid;
  assign out_ch.status          = out_item.status;
  assign out_ch.served_class    = out_item.served_class;
  assign out_ch.served_caller   = out_item.served_caller;
  assign out_ch.served_receiver = out_item.served_receiver;
  assign out_ch.served_packets  = out_item.served_packets;
  assign out_ch.served_hidden   = out_item.served_hidden;
  assign out_ch.served_roaming  = out_item.served_roaming;
  assign out_ch.dismissed_count = out_item.dismissed_count;

`ifndef ASSERT_OFF
  // Commit never overwrites an untaken result
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ch.ready))
    else $error("commit while result register occupied");

  // Every commit presents a result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("commit without result");

  // A real request closes the input until it is committed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op != OP_NONE) |=> !in_ch.ready)
    else $error("input reopened with request in flight");
`endif

endmodule
